// File: sv/assert_macros.svh
// Assertion macros shared by the ELU activation RTL.
// Both macros sample on aclk; only the second one is gated by the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

// Check a property at every clock edge while out of reset.
`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`endif

// File: sv/elu_pkg.sv
// Shared types, constants and elaboration-time functions for the ELU activation unit.
// No dependencies; imported by every module of the block.
package elu_pkg;

    // Fixed number format of the data path (signed Q4.12)
    localparam int DATA_W           = 16;
    localparam int FRAC_W           = 12;
    localparam int ALPHA_W          = DATA_W - 1;
    localparam int TDATA_W          = 2 * DATA_W;
    localparam int TUSER_W          = 1;

    // exp table: segments over [-8, 0], entries in Q30
    localparam int DOMAIN_LOG2      = 3;
    localparam int SPAN_W           = FRAC_W + DOMAIN_LOG2;
    localparam int Q_W              = 30;
    localparam int EXP_W            = Q_W + 1;
    localparam int TAYLOR_TERMS     = 24;
    localparam int EXP_SEGMENTS_DEF = 256;

    localparam longint unsigned Q30_ONE    = 64'd1 << Q_W;
    localparam longint unsigned Q30_HALF   = 64'd1 << (Q_W - 1);
    localparam longint unsigned DOMAIN_END = 64'd1 << (Q_W + DOMAIN_LOG2);

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(1 << FRAC_W);

    // Pipeline depth of the whole unit
    localparam int NSTAGE = 6;

    typedef enum logic {
        OP_FORWARD  = 1'b0,
        OP_BACKWARD = 1'b1
    } op_t;

    // Load enables of the first four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // Q30 product, rounded half up
    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + Q30_HALF) >> Q_W;
    endfunction

    // Truncated quotient by shift and subtract; the dividend stays below 2^32
    function automatic longint unsigned div_small(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            r = (r << 1) | ((n >> b) & 64'd1);
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // exp(-f) in Q30 for 0 <= f <= 1.0 (Q30), truncated Taylor series
    function automatic longint unsigned exp_neg_frac(longint unsigned f);
        longint          sum;
        longint unsigned term;
        sum  = longint'(Q30_ONE);
        term = Q30_ONE;
        for (int K = 1; K <= TAYLOR_TERMS; K++) begin
            term = div_small(q30_mul(term, f), longint'(K));
            if (K[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(Q30_ONE)) begin
            sum = longint'(Q30_ONE);
        end
        return longint'(sum);
    endfunction

    // exp(-t) in Q30 for t in Q30, 0 <= t <= 8.0
    function automatic logic [EXP_W-1:0] exp_entry(longint unsigned t);
        longint unsigned e1;
        longint unsigned v;
        longint unsigned n;
        e1 = exp_neg_frac(Q30_ONE);
        n  = t >> Q_W;
        v  = exp_neg_frac(t & (Q30_ONE - 64'd1));
        for (int j = 0; j < 8; j++) begin
            if (longint'(j) < longint'(n)) begin
                v = q30_mul(v, e1);
            end
        end
        return v[EXP_W-1:0];
    endfunction

endpackage

// File: sv/elu_exp_unit.sv
// Negative-branch exp path: segment index, table read, linear interpolation, 1 - exp.
// Four pipeline stages; depends on elu_pkg for the table builder and widths.
module elu_exp_unit #(
    parameter int EXP_SEGMENTS = elu_pkg::EXP_SEGMENTS_DEF
) (
    input  logic                          aclk,
    input  elu_pkg::stage_en_t            stage_en,
    input  logic [elu_pkg::DATA_W-1:0]    value,     // forward input x, signed Q4.12
    output logic [elu_pkg::EXP_W-1:0]     em1        // 1 - exp(x) in Q30
);
    import elu_pkg::*;

    localparam int IDX_W  = $clog2(EXP_SEGMENTS);
    localparam int SEG_W  = $clog2(EXP_SEGMENTS + 1);
    localparam int POS_W  = SPAN_W + SEG_W;
    localparam int N_EVEN = EXP_SEGMENTS / 2 + 1;
    localparam int N_ODD  = (EXP_SEGMENTS + 1) / 2;
    localparam int EA_W   = $clog2(N_EVEN);
    localparam int OA_W   = $clog2(N_ODD);
    localparam int PROD_W = EXP_W + SPAN_W;

    localparam logic [SEG_W-1:0]    SEG_K      = SEG_W'(EXP_SEGMENTS);
    localparam logic [EXP_W-1:0]    LAST_ENTRY = exp_entry(DOMAIN_END);
    localparam logic [EXP_W-1:0]    ONE_Q30    = EXP_W'(Q30_ONE);
    localparam logic [PROD_W:0]     HALF_SPAN  = (PROD_W + 1)'(1) << (SPAN_W - 1);

    // Constant table split into even and odd entries, so that both ends of a
    // segment come from different banks
    logic [EXP_W-1:0] even_bank [N_EVEN];
    logic [EXP_W-1:0] odd_bank  [N_ODD];

    for (genvar j = 0; j <= EXP_SEGMENTS; j++) begin : g_tab
        localparam longint unsigned TPOS =
            (longint'(j) << (Q_W + DOMAIN_LOG2)) / EXP_SEGMENTS;
        localparam logic [EXP_W-1:0] ENTRY = exp_entry(TPOS);
        if (j % 2 == 0) begin : g_even
            assign even_bank[j / 2] = ENTRY;
        end else begin : g_odd
            assign odd_bank[j / 2] = ENTRY;
        end
    end

    // Stage 1: magnitude of x, segment index and remainder
    logic [DATA_W:0]      mag_next;
    logic [POS_W-1:0]     pos_next;
    logic                 hi_next;
    logic [IDX_W-1:0]     idx1_reg;
    logic [SPAN_W-1:0]    rem1_reg;
    logic                 hi1_reg;

    assign mag_next = (DATA_W + 1)'(0) - {value[DATA_W-1], value};
    assign hi_next  = (mag_next[DATA_W:SPAN_W] != '0);
    assign pos_next = POS_W'(mag_next[SPAN_W-1:0]) * POS_W'(SEG_K);

    always_ff @(posedge aclk) begin
        if (stage_en.s1) begin
            idx1_reg <= pos_next[SPAN_W +: IDX_W];
            rem1_reg <= pos_next[SPAN_W-1:0];
            hi1_reg  <= hi_next;
        end
    end

    // Stage 2: read both segment ends, take their difference
    logic [IDX_W:0]       idx_inc;
    logic [EA_W-1:0]      even_addr;
    logic [OA_W-1:0]      odd_addr;
    logic [EXP_W-1:0]     ent_lo;
    logic [EXP_W-1:0]     ent_hi;
    logic                 down_next;
    logic [EXP_W-1:0]     diff_next;
    logic [EXP_W-1:0]     a2_reg;
    logic [EXP_W-1:0]     diff2_reg;
    logic                 down2_reg;
    logic [SPAN_W-1:0]    rem2_reg;

    assign idx_inc   = (IDX_W + 1)'(idx1_reg) + (IDX_W + 1)'(1);
    assign even_addr = idx_inc[EA_W:1];
    assign odd_addr  = idx1_reg[OA_W:1];

    always_comb begin
        if (hi1_reg) begin
            ent_lo = LAST_ENTRY;
            ent_hi = LAST_ENTRY;
        end else if (idx1_reg[0]) begin
            ent_lo = odd_bank[odd_addr];
            ent_hi = even_bank[even_addr];
        end else begin
            ent_lo = even_bank[even_addr];
            ent_hi = odd_bank[odd_addr];
        end
        down_next = (ent_lo >= ent_hi);
        diff_next = down_next ? (ent_lo - ent_hi) : (ent_hi - ent_lo);
    end

    always_ff @(posedge aclk) begin
        if (stage_en.s2) begin
            a2_reg    <= ent_lo;
            diff2_reg <= diff_next;
            down2_reg <= down_next;
            rem2_reg  <= rem1_reg;
        end
    end

    // Stage 3: scale the difference by the remainder, form 1 - a
    logic [PROD_W-1:0]    prod3_reg;
    logic [EXP_W-1:0]     na3_reg;
    logic                 down3_reg;

    always_ff @(posedge aclk) begin
        if (stage_en.s3) begin
            prod3_reg <= PROD_W'(diff2_reg) * PROD_W'(rem2_reg);
            na3_reg   <= ONE_Q30 - a2_reg;
            down3_reg <= down2_reg;
        end
    end

    // Stage 4: round the step to Q30 and apply it to 1 - a
    logic [PROD_W:0]      step_rnd;
    logic [EXP_W-1:0]     step_q;
    logic [EXP_W-1:0]     em1_next;
    logic [EXP_W-1:0]     em1_reg;

    assign step_rnd = (PROD_W + 1)'(prod3_reg) + HALF_SPAN;
    assign step_q   = step_rnd[SPAN_W +: EXP_W];
    assign em1_next = down3_reg ? (na3_reg + step_q) : (na3_reg - step_q);

    always_ff @(posedge aclk) begin
        if (stage_en.s4) begin
            em1_reg <= em1_next;
        end
    end

    assign em1 = em1_reg;

endmodule

// File: sv/elu_grad_unit.sv
// Backward path: grad * (y + alpha) with magnitude rounding and saturation.
// Three pipeline stages plus a rounding step read by the next stage; uses elu_pkg.
module elu_grad_unit (
    input  logic                          aclk,
    input  elu_pkg::stage_en_t            stage_en,
    input  logic [elu_pkg::DATA_W-1:0]    value,     // forward output y, signed Q4.12
    input  logic [elu_pkg::DATA_W-1:0]    grad,      // incoming gradient, signed Q4.12
    input  logic [elu_pkg::ALPHA_W-1:0]   alpha,     // unsigned Q3.12
    output logic [elu_pkg::DATA_W-1:0]    grad_res   // saturated product, signed Q4.12
);
    import elu_pkg::*;

    localparam int MUL_W = 2 * DATA_W;
    localparam int MAG_W = MUL_W + 1 - FRAC_W;

    localparam logic [MUL_W:0]      HALF_LSB  = (MUL_W + 1)'(1) << (FRAC_W - 1);
    localparam logic [MAG_W-1:0]    POS_LIM   = MAG_W'((1 << (DATA_W - 1)) - 1);
    localparam logic [MAG_W-1:0]    NEG_LIM   = MAG_W'(1 << (DATA_W - 1));
    localparam logic [DATA_W-1:0]   SAT_MAX   = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0]   SAT_MIN   = {1'b1, {(DATA_W - 1){1'b0}}};

    // Stage 1: y + alpha at one extra bit
    logic [DATA_W:0]      sum_next;
    logic [DATA_W:0]      sum1_reg;
    logic [DATA_W-1:0]    grad1_reg;

    assign sum_next = {value[DATA_W-1], value} + (DATA_W + 1)'(alpha);

    always_ff @(posedge aclk) begin
        if (stage_en.s1) begin
            sum1_reg  <= sum_next;
            grad1_reg <= grad;
        end
    end

    // Stage 2: split both operands into sign and magnitude
    logic [DATA_W:0]      sum_abs;
    logic [DATA_W-1:0]    grad_abs;
    logic [DATA_W-1:0]    ms2_reg;
    logic [DATA_W-1:0]    mg2_reg;
    logic                 neg2_reg;

    assign sum_abs  = sum1_reg[DATA_W] ? ((DATA_W + 1)'(0) - sum1_reg) : sum1_reg;
    assign grad_abs = grad1_reg[DATA_W-1] ? (DATA_W'(0) - grad1_reg) : grad1_reg;

    always_ff @(posedge aclk) begin
        if (stage_en.s2) begin
            ms2_reg  <= sum_abs[DATA_W-1:0];
            mg2_reg  <= grad_abs;
            neg2_reg <= sum1_reg[DATA_W] ^ grad1_reg[DATA_W-1];
        end
    end

    // Stage 3: magnitude product
    logic [MUL_W-1:0]     prod3_reg;
    logic                 neg3_reg;

    always_ff @(posedge aclk) begin
        if (stage_en.s3) begin
            prod3_reg <= MUL_W'(ms2_reg) * MUL_W'(mg2_reg);
            neg3_reg  <= neg2_reg;
        end
    end

    // Round half up on the magnitude, restore the sign, clamp
    logic [MUL_W:0]       prod_rnd;
    logic [MAG_W-1:0]     mag;

    assign prod_rnd = (MUL_W + 1)'(prod3_reg) + HALF_LSB;
    assign mag      = prod_rnd[MUL_W:FRAC_W];

    always_comb begin
        if (neg3_reg) begin
            grad_res = (mag > NEG_LIM) ? SAT_MIN : (DATA_W'(0) - mag[DATA_W-1:0]);
        end else begin
            grad_res = (mag > POS_LIM) ? SAT_MAX : mag[DATA_W-1:0];
        end
    end

endmodule

// File: sv/elu_activation_unit.sv
// Top level of the ELU activation unit: stream ports, alpha register, stage control.
// Instantiates elu_exp_unit and elu_grad_unit; uses elu_pkg and assert_macros.svh.
//
//   channel   ports                          direction  payload
//   input     s_tvalid s_tready s_tdata      in         value, grad; op in s_tuser
//   result    m_tvalid m_tready m_tdata      out        result
//   config    cfg_valid cfg_ready cfg_data   in         alpha
//
// Six register stages; one item can enter on every clock while the result side
// accepts results. Stage 3 holds two multipliers (segment interpolation, gradient
// product) and stage 5 one (alpha scaling).
// s_tready drops only when all six stages hold items and m_tready is low; a stage
// with no item always loads, so bubbles close up under a stall.
// Reset empties the pipeline and sets alpha to 1.0; the exp table is constant.
`include "assert_macros.svh"

module elu_activation_unit #(
    parameter int EXP_SEGMENTS = elu_pkg::EXP_SEGMENTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [elu_pkg::TDATA_W-1:0]    s_tdata,    // value [15:0], grad [31:16]
    input  logic [elu_pkg::TUSER_W-1:0]    s_tuser,    // op [0]
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [elu_pkg::DATA_W-1:0]     m_tdata,    // result [15:0]
    // alpha write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [elu_pkg::ALPHA_W-1:0]    cfg_data
);
    import elu_pkg::*;

    localparam int SCALE_W = ALPHA_W + EXP_W;

    localparam logic [SCALE_W:0]    SCALE_HALF = (SCALE_W + 1)'(Q30_HALF);
    localparam logic [SCALE_W-Q_W:0] NEG_LIM   = (SCALE_W - Q_W + 1)'(1 << (DATA_W - 1));
    localparam logic [DATA_W-1:0]   SAT_MIN    = {1'b1, {(DATA_W - 1){1'b0}}};

    // Alpha register; always ready for a write
    logic [ALPHA_W-1:0] alpha_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
        end else if (cfg_valid) begin
            alpha_reg <= cfg_data;
        end
    end

    // Stage valids and load enables; a stage loads when empty or when the next one loads
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] en;
    stage_en_t         stage_en;

    always_comb begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign vld_next = {vld_reg[NSTAGE-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTAGE; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign stage_en = '{s1: en[0], s2: en[1], s3: en[2], s4: en[3]};
    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NSTAGE-1];

    // Unpack the input transfer and pick the branch
    logic [DATA_W-1:0] value_in;
    logic [DATA_W-1:0] grad_in;
    op_t               op_in;
    logic              nonpos;
    logic              use_exp_next;
    logic              bwd_mul_next;
    logic [DATA_W-1:0] pass_next;

    assign value_in     = s_tdata[DATA_W-1:0];
    assign grad_in      = s_tdata[TDATA_W-1:DATA_W];
    assign op_in        = op_t'(s_tuser[0]);
    assign nonpos       = value_in[DATA_W-1] || (value_in == '0);
    assign use_exp_next = (op_in == OP_FORWARD) && nonpos;
    assign bwd_mul_next = (op_in == OP_BACKWARD) && nonpos;
    assign pass_next    = (op_in == OP_FORWARD) ? value_in : grad_in;

    // Data paths
    logic [EXP_W-1:0]  em1;
    logic [DATA_W-1:0] grad_res;

    elu_exp_unit #(
        .EXP_SEGMENTS (EXP_SEGMENTS)
    ) u_exp (
        .aclk     (aclk),
        .stage_en (stage_en),
        .value    (value_in),
        .em1      (em1)
    );

    elu_grad_unit u_grad (
        .aclk     (aclk),
        .stage_en (stage_en),
        .value    (value_in),
        .grad     (grad_in),
        .alpha    (alpha_reg),
        .grad_res (grad_res)
    );

    // Stages 1 to 3: carry the branch flags and the pass-through value
    logic              use_exp1_reg, use_exp2_reg, use_exp3_reg;
    logic              bwd_mul1_reg, bwd_mul2_reg, bwd_mul3_reg;
    logic [DATA_W-1:0] pass1_reg, pass2_reg, pass3_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            use_exp1_reg <= use_exp_next;
            bwd_mul1_reg <= bwd_mul_next;
            pass1_reg    <= pass_next;
        end
        if (en[1]) begin
            use_exp2_reg <= use_exp1_reg;
            bwd_mul2_reg <= bwd_mul1_reg;
            pass2_reg    <= pass1_reg;
        end
        if (en[2]) begin
            use_exp3_reg <= use_exp2_reg;
            bwd_mul3_reg <= bwd_mul2_reg;
            pass3_reg    <= pass2_reg;
        end
    end

    // Stage 4: merge the gradient result into the side value
    logic              use_exp4_reg;
    logic [DATA_W-1:0] alt4_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            use_exp4_reg <= use_exp3_reg;
            alt4_reg     <= bwd_mul3_reg ? grad_res : pass3_reg;
        end
    end

    // Stage 5: scale 1 - exp by alpha
    logic               use_exp5_reg;
    logic [DATA_W-1:0]  alt5_reg;
    logic [SCALE_W-1:0] scale5_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            use_exp5_reg <= use_exp4_reg;
            alt5_reg     <= alt4_reg;
            scale5_reg   <= SCALE_W'(alpha_reg) * SCALE_W'(em1);
        end
    end

    // Stage 6: round out of Q30, negate, clamp, select the result
    logic [SCALE_W:0]      scale_rnd;
    logic [SCALE_W-Q_W:0]  exp_mag;
    logic [DATA_W-1:0]     exp_res;
    logic [DATA_W-1:0]     result_next;
    logic [DATA_W-1:0]     result_reg;

    assign scale_rnd   = (SCALE_W + 1)'(scale5_reg) + SCALE_HALF;
    assign exp_mag     = scale_rnd[SCALE_W:Q_W];
    assign exp_res     = (exp_mag > NEG_LIM) ? SAT_MIN
                                             : (DATA_W'(0) - exp_mag[DATA_W-1:0]);
    assign result_next = use_exp5_reg ? exp_res : alt5_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            result_reg <= result_next;
        end
    end

    assign m_tdata = result_reg;

    // Checks on the stage control
    `ASSERT_CLK(a_reset_empties, !aresetn |=> !m_tvalid, "result valid right after reset")
    `ASSERT_CLK_RST(a_stall_only_full, !s_tready |-> ((&vld_reg) && !m_tready), "input stalled with room in pipeline")
    `ASSERT_CLK_RST(a_accept_enters, (s_tvalid && s_tready) |=> vld_reg[0], "accepted transfer missing from first stage")
    `ASSERT_CLK_RST(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid, "stalled result dropped")

endmodule

// File: dv/tb_elu_activation_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for elu_activation_unit: forward ELU and backward gradient.
// Depends on elu_pkg (widths, constants, op encoding) and on elu_activation_unit.
module tb_elu_activation_unit;
    import elu_pkg::*;

    localparam int SEGS         = EXP_SEGMENTS_DEF;
    localparam longint SAT_HI   = (64'sd1 <<< (DATA_W - 1)) - 1;
    localparam longint SAT_LO   = -SAT_HI - 1;
    localparam int DRAIN_CYCLES = 20000;
    localparam int TIMEOUT_NS   = 1_000_000;
    localparam int PHASE_ITEMS  = 200;

    // Expected-result store plus a bit-exact copy of the ELU datapath
    class elu_scoreboard;
        longint unsigned    exp_q30 [0:SEGS];
        logic [ALPHA_W-1:0] alpha;
        logic [DATA_W-1:0]  elu_expected [$];
        int unsigned        errors;

        function new();
            longint unsigned e1, tq, n, v, kk;
            e1 = exp_neg(Q30_ONE);
            for (kk = 0; kk <= SEGS; kk++) begin
                tq = (kk << (Q_W + DOMAIN_LOG2)) / SEGS;
                n  = tq >> Q_W;
                v  = exp_neg(tq & (Q30_ONE - 1));
                repeat (n) v = mul_q30(v, e1);
                exp_q30[kk] = v;
            end
            alpha  = ALPHA_RESET;
            errors = 0;
        endfunction

        function longint unsigned mul_q30(longint unsigned a, longint unsigned b);
            return (a * b + Q30_HALF) >> Q_W;
        endfunction

        // exp(-f) for f in [0, 1.0] in Q30, 24-term series
        function longint unsigned exp_neg(longint unsigned f);
            longint          sum;
            longint unsigned term;
            sum  = longint'(Q30_ONE);
            term = Q30_ONE;
            for (int k = 1; k <= 24; k++) begin
                term = mul_q30(term, f) / k;
                if (k % 2 == 1) begin
                    sum -= longint'(term);
                end else begin
                    sum += longint'(term);
                end
            end
            if (sum < 0) sum = 0;
            if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
            return sum;
        endfunction

        // exp(-t) in Q30, t in Q4.12; interpolate between table entries
        function longint unsigned exp_at(longint unsigned t);
            longint unsigned span, pos, idx, rem, a, b;
            span = 64'd1 << SPAN_W;
            if (t >= span) return exp_q30[SEGS];
            pos = t * SEGS;
            idx = pos / span;
            rem = pos % span;
            a   = exp_q30[idx];
            b   = exp_q30[idx + 1];
            if (a >= b) return a - (((a - b) * rem + span / 2) / span);
            return a + (((b - a) * rem + span / 2) / span);
        endfunction

        function logic [DATA_W-1:0] elu_of(op_t op, logic signed [DATA_W-1:0] v,
                                           logic signed [DATA_W-1:0] g);
            longint          vv, gg, s, r;
            longint unsigned m, ms, mg;
            logic            neg;
            vv = v;
            gg = g;
            if (vv > 0) begin
                r = (op == OP_FORWARD) ? vv : gg;
            end else if (op == OP_FORWARD) begin
                m = (alpha * (Q30_ONE - exp_at(-vv)) + Q30_HALF) >> Q_W;
                r = -longint'(m);
            end else begin
                // gradient scaled by (y + alpha), magnitude rounded half up
                s   = vv + longint'(alpha);
                neg = (s < 0) != (gg < 0);
                ms  = (s < 0) ? -s : s;
                mg  = (gg < 0) ? -gg : gg;
                m   = (ms * mg + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
                if (m > (64'd1 << DATA_W)) m = 64'd1 << DATA_W;
                r = neg ? -longint'(m) : longint'(m);
            end
            if (r > SAT_HI) r = SAT_HI;
            if (r < SAT_LO) r = SAT_LO;
            return r[DATA_W-1:0];
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] ERROR: %s", $time, msg);
        endtask

        task note_item(op_t op, logic [DATA_W-1:0] v, logic [DATA_W-1:0] g);
            elu_expected.push_back(elu_of(op, v, g));
        endtask

        task check_result(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (elu_expected.size() == 0) begin
                report($sformatf("unexpected result transfer 0x%04h", got));
            end else begin
                want = elu_expected.pop_front();
                if (got !== want)
                    report($sformatf("result 0x%04h, expected 0x%04h", got, want));
            end
        endtask

        function int pending();
            return elu_expected.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;    // value [15:0], grad [31:16]
    logic [TUSER_W-1:0]   s_tuser   = '0;    // op [0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;           // result [15:0]
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [ALPHA_W-1:0]   cfg_data  = '0;

    logic                 steady    = 1'b0;  // no idling on either side
    logic [ALPHA_W-1:0]   cur_alpha = ALPHA_RESET;
    elu_scoreboard        sb        = new();

    elu_activation_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Sample every transfer at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.alpha = cfg_data;
            if (s_tvalid && s_tready)
                sb.note_item(op_t'(s_tuser[0]), s_tdata[15:0], s_tdata[31:16]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // Result side: stall at random unless in the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 35);
    end

    // Hold off a random number of cycles, then present one item until taken
    task automatic send_item(op_t op, logic [DATA_W-1:0] value, logic [DATA_W-1:0] grad);
        while (!steady && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {grad, value};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending, let the last transfer reach the scoreboard, wait for every
    // outstanding result, then let the pipe settle
    task automatic wait_drained();
        int unsigned n;
        s_tvalid <= 1'b0;
        n = 0;
        @(posedge aclk);
        while (sb.pending() != 0 && n < DRAIN_CYCLES) begin
            @(posedge aclk);
            n++;
        end
        repeat (NSTAGE + 4) @(posedge aclk);
    endtask

    task automatic write_alpha(logic [ALPHA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        cur_alpha  = val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_corner();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    // Mix of full range, near zero, corners and the [-alpha, 0] band
    function automatic logic [DATA_W-1:0] pick_value(int unsigned scale);
        case ($urandom_range(0, 7))
            0, 1, 2: return 16'($urandom);
            3, 4:    return 16'($urandom_range(0, 1024)) - 16'd512;
            5:       return pick_corner();
            default: return 16'd0 - 16'($urandom_range(0, scale));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_grad();
        return ($urandom_range(0, 4) == 0) ? pick_corner() : 16'($urandom);
    endfunction

    initial begin
        logic [ALPHA_W-1:0] next_alpha;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Forward: zero, tiny, extremes, segment edges, positive pass-through
        send_item(OP_FORWARD,  16'h0000, 16'hA5A5);
        send_item(OP_FORWARD,  16'h0001, 16'hA5A5);
        send_item(OP_FORWARD,  16'hFFFF, 16'h5A5A);
        send_item(OP_FORWARD,  16'h7FFF, 16'h0000);
        send_item(OP_FORWARD,  16'h8000, 16'hFFFF);
        send_item(OP_FORWARD,  16'h8001, 16'h8000);
        send_item(OP_FORWARD,  16'hF000, 16'h7FFF);
        send_item(OP_FORWARD,  16'hFF80, 16'h1234);
        send_item(OP_FORWARD,  16'hFF7F, 16'h1234);
        send_item(OP_FORWARD,  16'hFF81, 16'h1234);
        send_item(OP_FORWARD,  16'hB1E0, 16'h1234);
        send_item(OP_FORWARD,  16'h1000, 16'h1234);
        // Backward: y at zero, y+alpha at zero, saturation, pass-through, zero grad
        send_item(OP_BACKWARD, 16'h0000, 16'h7FFF);
        send_item(OP_BACKWARD, 16'h0000, 16'h8000);
        send_item(OP_BACKWARD, 16'h8000, 16'h8000);
        send_item(OP_BACKWARD, 16'h8000, 16'h7FFF);
        send_item(OP_BACKWARD, 16'hF000, 16'h1234);
        send_item(OP_BACKWARD, 16'hFFFF, 16'hFFFF);
        send_item(OP_BACKWARD, 16'h0001, 16'h8000);
        send_item(OP_BACKWARD, 16'h7FFF, 16'h0ABC);
        send_item(OP_BACKWARD, 16'hFC00, 16'h0000);
        send_item(OP_BACKWARD, 16'hF800, 16'h7FFF);
        wait_drained();

        // Random phases, each under its own alpha
        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       next_alpha = '0;
                1:       next_alpha = '1;
                2:       next_alpha = 15'd1;
                4:       next_alpha = ALPHA_RESET;
                5:       next_alpha = 15'd12288;
                default: next_alpha = 15'($urandom_range(0, 32767));
            endcase
            write_alpha(next_alpha);
            steady = (p == 4);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // hold the sender until the pipe is empty, mid-phase
                if (p == 2 && i == PHASE_ITEMS / 2) wait_drained();
                send_item(op_t'($urandom_range(0, 1)), pick_value(cur_alpha), pick_grad());
            end
            wait_drained();
        end

        steady = 1'b0;
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/elu_pkg.sv
sv/elu_exp_unit.sv
sv/elu_grad_unit.sv
sv/elu_activation_unit.sv
dv/tb_elu_activation_unit.sv
